@@ src/rsi_indicator_stream_top_macros.svh @@
// ----------------------------------------------------------------------------
// RSI indicator stream: assertion macros
// Property wrappers clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef RSI_INDICATOR_STREAM_TOP_MACROS_SVH
`define RSI_INDICATOR_STREAM_TOP_MACROS_SVH

`ifndef SYNTH
`define RSI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsi assertion failed");
`define RSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsi assertion failed");
`else
`define RSI_ASSERT_IMPLY(label, ante, cons)
`define RSI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// RSI package
// Shared constants, codes and handshake structs of the RSI indicator stream.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int PRICE_WIDTH_DEF         = 32;
  localparam int EXTRA_FRACTION_BITS_DEF = 16;

  localparam int RSI_W         = 15;
  localparam int RSI_FRAC_BITS = 8;
  localparam int MUL_STEPS     = 8;

  localparam logic [14:0] RSI_FULL_SCALE = 15'd25600;
  localparam logic [7:0]  RSI_PERCENT    = 8'd100;
  localparam logic [7:0]  SEEDED_MARK    = 8'd255;
  localparam logic [7:0]  MIN_PERIOD     = 8'd2;

  localparam logic [7:0] PERIOD_RESET = 8'd14;
  localparam logic [6:0] SELL_RESET   = 7'd70;
  localparam logic [6:0] BUY_RESET    = 7'd30;

  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_SELL   = 2'd1;
  localparam logic [1:0] CFG_BUY    = 2'd2;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;
  localparam logic [1:0] SIG_HOLD = 2'd3;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

endpackage

`default_nettype wire

@@ src/rsi_indicator_stream_top.sv @@
// ----------------------------------------------------------------------------
// RSI indicator stream, top level
// Wilder-smoothed relative strength index over a stream of closing prices,
// sequenced over one shared multiply/divide unit.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  close_price, series_start
//   out      out  out_valid / out_stall rsi_value, trade_signal
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Once seeded, each item runs its multiplies and divides in turn on the shared
// unit, and no new price is accepted until the item leaves the output state.
// The seed item skips two multiplies; a zero average loss skips the last two ops.
// A restart or an item still seeding returns to idle from the difference state.
// Reset is synchronous; registers take their reset values, no result pending.
// A stalled result sits in the output register while the next item works.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rsi_indicator_stream_top_macros.svh"

module rsi_indicator_stream_top #(
  parameter int PRICE_WIDTH         = rsi_pkg::PRICE_WIDTH_DEF,
  parameter int EXTRA_FRACTION_BITS = rsi_pkg::EXTRA_FRACTION_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [PRICE_WIDTH-1:0]    close_price,
  input  wire                       series_start,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [rsi_pkg::RSI_W-1:0] rsi_value,
  output logic [1:0]                trade_signal,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [1:0]                cfg_index,
  input  wire  [7:0]                cfg_data
);

  localparam int DW    = PRICE_WIDTH + EXTRA_FRACTION_BITS;
  localparam int ACC_W = (DW + 8 > 64) ? 64 : DW + 8;
  localparam int OP_W  = (DW + 15 > 64) ? 64 : DW + 15;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_GM   = 4'd2;
  localparam logic [3:0] S_GD   = 4'd3;
  localparam logic [3:0] S_LM   = 4'd4;
  localparam logic [3:0] S_LD   = 4'd5;
  localparam logic [3:0] S_RM   = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state, state_next;
  logic       issued, issued_next;

  logic [7:0] period;
  logic [6:0] sell;
  logic [6:0] buy;

  logic [PRICE_WIDTH-1:0] price_q;
  logic                   start_q;
  logic [PRICE_WIDTH-1:0] prev;
  logic                   have_prev;
  logic [7:0]             seen;
  logic [ACC_W-1:0]       avg_gain;
  logic [ACC_W-1:0]       avg_loss;
  logic [ACC_W-1:0]       gain_r;
  logic [ACC_W-1:0]       loss_r;
  logic [OP_W-1:0]        tmp;
  logic [OP_W-1:0]        rsi_q;
  logic [7:0]             dvs;
  logic                   seed;

  logic                   up;
  logic [PRICE_WIDTH-1:0] mag;
  logic [DW-1:0]          mag_sh;
  logic [ACC_W-1:0]       delta;
  logic [7:0]             p_eff;
  logic [7:0]             count;
  logic [OP_W-1:0]        sum_w;
  logic                   full_scale;

  rsi_pkg::arith_req_t req;
  rsi_pkg::arith_rsp_t rsp;
  logic                req_start;
  logic                req_op;
  logic [OP_W-1:0]     ar_a;
  logic [7:0]          ar_b;
  logic [OP_W-1:0]     ar_c;
  logic [OP_W-1:0]     ar_res;

  rsi_arith #(
    .W (OP_W)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .a   (ar_a),
    .b   (ar_b),
    .c   (ar_c),
    .res (ar_res),
    .rsp (rsp)
  );

  assign req       = '{start: req_start, op: req_op};
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign up         = price_q > prev;
  assign mag        = up ? (price_q - prev) : (prev - price_q);
  assign mag_sh     = DW'(mag) << EXTRA_FRACTION_BITS;
  assign delta      = ACC_W'(mag_sh);
  assign p_eff      = (period < rsi_pkg::MIN_PERIOD) ? rsi_pkg::MIN_PERIOD : period;
  assign count      = seen + 8'd1;
  assign sum_w      = OP_W'(avg_gain) + OP_W'(avg_loss);
  assign full_scale = (avg_loss == '0) || (sum_w == '0);

  always_comb begin
    req_op = rsi_pkg::OP_MUL;
    ar_a   = '0;
    ar_b   = '0;
    ar_c   = '0;
    case (state)
      S_GM: begin
        ar_a = OP_W'(avg_gain);
        ar_b = dvs - 8'd1;
        ar_c = OP_W'(gain_r);
      end
      S_GD: begin
        req_op = rsi_pkg::OP_DIV;
        ar_a   = seed ? OP_W'(avg_gain) : tmp;
        ar_c   = OP_W'(dvs);
      end
      S_LM: begin
        ar_a = OP_W'(avg_loss);
        ar_b = dvs - 8'd1;
        ar_c = OP_W'(loss_r);
      end
      S_LD: begin
        req_op = rsi_pkg::OP_DIV;
        ar_a   = seed ? OP_W'(avg_loss) : tmp;
        ar_c   = OP_W'(dvs);
      end
      S_RM: begin
        ar_a = OP_W'(avg_gain);
        ar_b = rsi_pkg::RSI_PERCENT;
      end
      S_RD: begin
        req_op = rsi_pkg::OP_DIV;
        ar_a   = tmp << rsi_pkg::RSI_FRAC_BITS;
        ar_c   = sum_w;
      end
      default: req_op = rsi_pkg::OP_MUL;
    endcase
  end

  always_comb begin
    state_next  = state;
    issued_next = issued;
    req_start   = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIFF;
      S_DIFF: begin
        if (start_q || !have_prev) state_next = S_IDLE;
        else if (seen != rsi_pkg::SEEDED_MARK)
          state_next = (count < p_eff) ? S_IDLE : S_GD;
        else state_next = S_GM;
      end
      S_GM, S_GD, S_LM, S_LD, S_RD: begin
        req_start   = !issued;
        issued_next = 1'b1;
        if (rsp.done) begin
          issued_next = 1'b0;
          case (state)
            S_GM:    state_next = S_GD;
            S_GD:    state_next = seed ? S_LD : S_LM;
            S_LM:    state_next = S_LD;
            S_LD:    state_next = S_RM;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_RM: begin
        if (full_scale) begin
          state_next = S_OUT;
        end else begin
          req_start   = !issued;
          issued_next = 1'b1;
          if (rsp.done) begin
            issued_next = 1'b0;
            state_next  = S_RD;
          end
        end
      end
      S_OUT: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      period    <= rsi_pkg::PERIOD_RESET;
      sell      <= rsi_pkg::SELL_RESET;
      buy       <= rsi_pkg::BUY_RESET;
      prev      <= '0;
      have_prev <= 1'b0;
      seen      <= '0;
      avg_gain  <= '0;
      avg_loss  <= '0;
      seed      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;

      if (cfg_valid) begin
        case (cfg_index)
          rsi_pkg::CFG_PERIOD: period <= cfg_data;
          rsi_pkg::CFG_SELL:   sell   <= cfg_data[6:0];
          rsi_pkg::CFG_BUY:    buy    <= cfg_data[6:0];
          default:             period <= period;
        endcase
      end

      if (state == S_IDLE && in_valid) begin
        price_q <= close_price;
        start_q <= series_start;
      end

      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_DIFF: begin
          prev <= price_q;
          if (start_q || !have_prev) begin
            have_prev <= 1'b1;
            seen      <= '0;
            avg_gain  <= '0;
            avg_loss  <= '0;
          end else begin
            gain_r <= up ? delta : '0;
            loss_r <= up ? '0 : delta;
            if (seen != rsi_pkg::SEEDED_MARK) begin
              avg_gain <= avg_gain + (up ? delta : '0);
              avg_loss <= avg_loss + (up ? '0 : delta);
              seen     <= (count < p_eff) ? count : rsi_pkg::SEEDED_MARK;
              dvs      <= count;
              seed     <= 1'b1;
            end else begin
              dvs  <= p_eff;
              seed <= 1'b0;
            end
          end
        end
        S_GM, S_LM: if (rsp.done) tmp <= ar_res;
        S_GD: if (rsp.done) avg_gain <= ACC_W'(ar_res);
        S_LD: if (rsp.done) avg_loss <= ACC_W'(ar_res);
        S_RM: begin
          if (full_scale) rsi_q <= OP_W'(rsi_pkg::RSI_FULL_SCALE);
          else if (rsp.done) tmp <= ar_res;
        end
        S_RD: if (rsp.done) rsi_q <= ar_res;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            rsi_value <= rsi_q[rsi_pkg::RSI_W-1:0];
            if (seed)
              trade_signal <= rsi_pkg::SIG_NONE;
            else if (rsi_q > (OP_W'(sell) << rsi_pkg::RSI_FRAC_BITS))
              trade_signal <= rsi_pkg::SIG_SELL;
            else if (rsi_q < (OP_W'(buy) << rsi_pkg::RSI_FRAC_BITS))
              trade_signal <= rsi_pkg::SIG_BUY;
            else
              trade_signal <= rsi_pkg::SIG_HOLD;
          end
        end
        default: seed <= seed;
      endcase
    end
  end

  `RSI_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_DIFF)
  `RSI_ASSERT_NEXT(a_load_from_out, !out_valid && state != S_OUT, !out_valid)
  `RSI_ASSERT_IMPLY(a_idle_unit_quiet, state == S_IDLE || state == S_DIFF, !rsp.busy)

endmodule

`default_nettype wire

@@ src/rsi_arith.sv @@
// ----------------------------------------------------------------------------
// RSI arithmetic unit
// Iterative shift-add multiplier (a * b + c) and restoring divider (a / c),
// one bit per cycle, sharing the accumulator and operand registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_arith #(
  parameter int W = 63
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rsi_pkg::arith_req_t  req,
  input  wire  [W-1:0]         a,
  input  wire  [7:0]           b,
  input  wire  [W-1:0]         c,
  output logic [W-1:0]         res,
  output rsi_pkg::arith_rsp_t  rsp
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic             op;
  logic [W-1:0]     acc;
  logic [W-1:0]     opd;
  logic [W-1:0]     rem;
  logic [7:0]       mplier;
  logic [CNT_W-1:0] count;

  logic [W:0] rem_sh;
  logic [W:0] trial;
  logic       fits;

  assign rem_sh = {rem, acc[W-1]};
  assign trial  = rem_sh - {1'b0, opd};
  assign fits   = ~trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        op   <= req.op;
        if (req.op == rsi_pkg::OP_DIV) begin
          count <= CNT_W'(W);
          acc   <= a;
          opd   <= c;
          rem   <= '0;
        end else begin
          count  <= CNT_W'(rsi_pkg::MUL_STEPS);
          acc    <= c;
          opd    <= a;
          mplier <= b;
        end
      end else if (busy) begin
        count <= count - CNT_W'(1);
        done  <= (count == CNT_W'(1));
        if (count == CNT_W'(1)) busy <= 1'b0;
        case (op)
          rsi_pkg::OP_MUL: begin
            if (mplier[0]) acc <= acc + opd;
            opd    <= opd << 1;
            mplier <= mplier >> 1;
          end
          rsi_pkg::OP_DIV: begin
            acc <= {acc[W-2:0], fits};
            rem <= fits ? trial[W-1:0] : rem_sh[W-1:0];
          end
          default: acc <= acc;
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign res = acc;
  assign rsp = '{busy: busy, done: done};

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI indicator stream testbench
// Feeds closing-price series through rsi_indicator_stream_top and checks each
// RSI transfer against an in-bench Wilder RSI tracker, over several register
// settings and three idling patterns on the price and result channels.
// ----------------------------------------------------------------------------
module testbench;

  import rsi_pkg::*;

  localparam int CLOSE_W       = PRICE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [CLOSE_W-1:0] price;
    logic               restart;
  } price_tick_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic [1:0]       sig;
  } rsi_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CLOSE_W-1:0] close_price = '0;
  logic               series_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RSI_W-1:0]   rsi_value;
  logic [1:0]         trade_signal;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  price_tick_t tick_backlog[$];
  rsi_result_t rsi_expected[$];
  int          send_idle_pct = 37;
  int          recv_idle_pct = 45;
  int          bad_results = 0;
  logic [CLOSE_W-1:0] last_queued = '0;

  // tracker state and register copies
  logic [7:0]         period_cfg = PERIOD_RESET;
  logic [6:0]         sell_cfg   = SELL_RESET;
  logic [6:0]         buy_cfg    = BUY_RESET;
  logic [CLOSE_W-1:0] last_close = '0;
  logic               primed = 1'b0;
  logic [7:0]         change_count = '0;
  logic [63:0]        gain_avg = '0;
  logic [63:0]        loss_avg = '0;

  rsi_indicator_stream_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .close_price  (close_price),
    .series_start (series_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rsi_value    (rsi_value),
    .trade_signal (trade_signal),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] strength_q8(input logic [63:0] g, input logic [63:0] l);
    logic [63:0] total;
    total = g + l;
    if (l == 64'd0 || total == 64'd0) return 64'(RSI_FULL_SCALE);
    return (64'(RSI_FULL_SCALE) * g) / total;
  endfunction

  function automatic void track_close(input logic [CLOSE_W-1:0] price, input logic restart);
    logic [63:0] up;
    logic [63:0] down;
    logic [63:0] p;
    logic [63:0] count;
    logic [63:0] rsi;
    rsi_result_t r;
    up   = '0;
    down = '0;
    if (restart || !primed) begin
      last_close   = price;
      primed       = 1'b1;
      change_count = '0;
      gain_avg     = '0;
      loss_avg     = '0;
      return;
    end
    if (price > last_close) up = 64'(price - last_close) << EXTRA_FRACTION_BITS_DEF;
    else down = 64'(last_close - price) << EXTRA_FRACTION_BITS_DEF;
    last_close = price;
    p = (period_cfg < MIN_PERIOD) ? 64'(MIN_PERIOD) : 64'(period_cfg);
    if (change_count < SEEDED_MARK) begin
      count    = 64'(change_count) + 64'd1;
      gain_avg = gain_avg + up;
      loss_avg = loss_avg + down;
      if (count < p) begin
        change_count = count[7:0];
        return;
      end
      gain_avg     = gain_avg / count;
      loss_avg     = loss_avg / count;
      change_count = SEEDED_MARK;
      rsi   = strength_q8(gain_avg, loss_avg);
      r.rsi = rsi[RSI_W-1:0];
      r.sig = SIG_NONE;
    end else begin
      gain_avg = (gain_avg * (p - 64'd1) + up) / p;
      loss_avg = (loss_avg * (p - 64'd1) + down) / p;
      rsi   = strength_q8(gain_avg, loss_avg);
      r.rsi = rsi[RSI_W-1:0];
      if (rsi > 64'(sell_cfg) * 64'd256) r.sig = SIG_SELL;
      else if (rsi < 64'(buy_cfg) * 64'd256) r.sig = SIG_BUY;
      else r.sig = SIG_HOLD;
    end
    rsi_expected.insert(rsi_expected.size(), r);
  endfunction

  // price channel
  always @(posedge clk) begin
    price_tick_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) track_close(close_price, series_start);
      if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tick_backlog.pop_front();
        close_price  <= nxt.price;
        series_start <= nxt.restart;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result channel
  always @(posedge clk) begin
    rsi_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (rsi_expected.size() == 0) begin
          $error("unexpected transfer: rsi_value %0d, trade_signal %0d", rsi_value, trade_signal);
          bad_results++;
        end else begin
          want = rsi_expected.pop_front();
          if (rsi_value !== want.rsi) begin
            $error("rsi_value: expected %0d, got %0d", want.rsi, rsi_value);
            bad_results++;
          end
          if (trade_signal !== want.sig) begin
            $error("trade_signal: expected %0d, got %0d", want.sig, trade_signal);
            bad_results++;
          end
        end
      end
    end
  end

  task automatic program_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PERIOD: period_cfg = val;
      CFG_SELL:   sell_cfg   = val[6:0];
      CFG_BUY:    buy_cfg    = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle_block();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || in_valid || rsi_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_tick(input logic [CLOSE_W-1:0] price, input logic restart);
    price_tick_t t;
    t.price   = price;
    t.restart = restart;
    tick_backlog.insert(tick_backlog.size(), t);
    last_queued = price;
  endtask

  function automatic logic [CLOSE_W-1:0] next_close(input logic [CLOSE_W-1:0] prev);
    logic [CLOSE_W-1:0] step;
    step = $urandom() >> $urandom_range(4, 31);
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return '0;
      2:       return '1;
      3:       return prev;
      4, 5, 6: return prev + step;
      default: return prev - step;
    endcase
  endfunction

  task automatic queue_random_closes(input int n, input int restart_pct);
    logic               rs;
    logic [CLOSE_W-1:0] px;
    for (int i = 0; i < n; i++) begin
      rs = (i == 0) ? 1'b1 : ($urandom_range(99) < restart_pct);
      px = rs ? $urandom() : next_close(last_queued);
      queue_tick(px, rs);
    end
  endtask

  task automatic random_settings();
    logic [7:0] per;
    logic [7:0] sl;
    logic [7:0] bl;
    case ($urandom_range(9))
      0:       per = 8'($urandom_range(0, 1));
      1:       per = 8'($urandom_range(21, 60));
      default: per = 8'($urandom_range(2, 20));
    endcase
    sl = 8'(($urandom_range(9) == 0) ? $urandom_range(101, 127) : $urandom_range(50, 100));
    bl = 8'(($urandom_range(9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 50));
    program_reg(CFG_PERIOD, per);
    program_reg(CFG_SELL, sl);
    program_reg(CFG_BUY, bl);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // period 0 behaves as 2
    program_reg(CFG_PERIOD, 8'd0);
    program_reg(CFG_SELL, 8'd70);
    program_reg(CFG_BUY, 8'd30);
    queue_tick(32'h0000_0000, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'h0000_0000, 1'b0);
    queue_tick(32'h0000_0000, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'h8000_0000, 1'b0);
    queue_tick(32'h1234_5678, 1'b1);
    queue_tick(32'h1234_5679, 1'b0);
    queue_tick(32'h1234_567A, 1'b0);
    queue_tick(32'h2000_0000, 1'b0);
    queue_tick(32'h0000_0100, 1'b1);
    queue_tick(32'h0000_0100, 1'b0);
    queue_tick(32'h0000_0100, 1'b0);
    queue_tick(32'h0000_0080, 1'b0);
    queue_tick(32'h0000_0040, 1'b0);
    queue_tick(32'h0000_0060, 1'b0);
    queue_tick(32'h0000_0040, 1'b0);
    queue_tick(32'h0000_0060, 1'b0);
    queue_tick(32'h5555_5555, 1'b1);
    queue_tick(32'hAAAA_AAAA, 1'b0);
    queue_tick(32'h5555_5555, 1'b0);
    settle_block();

    // period shortened part way through seeding
    program_reg(CFG_PERIOD, 8'd10);
    queue_random_closes(6, 0);
    settle_block();
    program_reg(CFG_PERIOD, 8'd3);
    queue_random_closes(1, 0);
    tick_backlog.delete();
    queue_tick(next_close(last_queued), 1'b0);
    queue_tick(next_close(last_queued), 1'b0);
    queue_tick(next_close(last_queued), 1'b0);
    settle_block();
    program_reg(CFG_PERIOD, 8'd5);
    for (int i = 0; i < 4; i++) queue_tick(next_close(last_queued), 1'b0);
    settle_block();

    // levels out of range, then at the extremes
    program_reg(CFG_SELL, 8'd127);
    program_reg(CFG_BUY, 8'd127);
    for (int i = 0; i < 4; i++) queue_tick(next_close(last_queued), 1'b0);
    settle_block();
    program_reg(CFG_SELL, 8'd0);
    program_reg(CFG_BUY, 8'd0);
    queue_tick(32'h0000_1000, 1'b1);
    for (int i = 0; i < 8; i++) queue_tick(32'h0000_1000 - 32'(i * 16), 1'b0);
    settle_block();
    program_reg(CFG_SELL, 8'd100);
    program_reg(CFG_BUY, 8'd100);
    for (int i = 0; i < 3; i++) queue_tick(next_close(last_queued), 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      settle_block();
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 45 : 0;
      recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 37 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        settle_block();
        random_settings();
        queue_random_closes(40, 3);
      end
    end

    // longest period
    settle_block();
    program_reg(CFG_PERIOD, 8'd255);
    queue_random_closes(270, 0);
    settle_block();

    if (bad_results == 0) begin
      $display("[rsi_indicator_stream_top] OK");
    end else begin
      $display("[rsi_indicator_stream_top] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[rsi_indicator_stream_top] ERROR");
    $finish;
  end

endmodule
